### rtl/mdio_mm_pkg.sv
// ----------------------------------------------------------------------------
// mdio_mm_pkg
// Shared types and constants for the clause-22 mdio management master.
// ----------------------------------------------------------------------------
package mdio_mm_pkg;

  // operation codes of a request word
  localparam logic [1:0] OP_IDLE  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // configuration register indexes
  localparam logic CFG_PREAMBLE_BITS = 1'b0;
  localparam logic CFG_HALF_PERIOD   = 1'b1;

  localparam logic [5:0] PREAMBLE_RESET    = 6'd33;
  localparam logic [7:0] HALF_PERIOD_RESET = 8'd1;

  // frame headers: start, opcode and turnaround fields
  localparam logic [5:0] READ_HEADER   = 6'b110110;
  localparam logic [3:0] WRITE_HEADER  = 4'b0101;
  localparam logic [1:0] WRITE_TA      = 2'b10;

  // bit counts of the frame phases
  localparam logic [5:0] READ_CMD_BITS  = 6'd16;
  localparam logic [5:0] WRITE_CMD_BITS = 6'd32;
  localparam logic [5:0] SAMPLE_BITS    = 6'd19;
  localparam logic [5:0] TRAIL_BITS     = 6'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  phy_id;
    logic [4:0]  reg_addr;
    logic [15:0] write_data;
    logic        mdio_in;
  } mdio_req_t;

  typedef struct packed {
    logic        mdc;
    logic        mdio_out;
    logic        mdio_drive;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;
  } mdio_res_t;

endpackage

### rtl/mdio_mm_if.sv
// ----------------------------------------------------------------------------
// mdio_mm_if
// Valid/ready channels carrying request and result words of the mdio master.
// ----------------------------------------------------------------------------
interface mdio_req_if;
  logic                   valid;
  logic                   ready;
  mdio_mm_pkg::mdio_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mdio_res_if;
  logic                   valid;
  logic                   ready;
  mdio_mm_pkg::mdio_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/mdio_management_master_unit.sv
// ----------------------------------------------------------------------------
// mdio_management_master_unit
// Clause-22 mdio master, one system tick per request word.
// ----------------------------------------------------------------------------
// a result word is registered in the output register, or in the skid entry while one waits
// throughput: one word per cycle while the skid entry is empty; ready drops when it is full
// a two-entry output stage lets requests flow while one result waits
// reset: synchronous, active high; idle, preamble 33, half period 1
// ----------------------------------------------------------------------------
module mdio_management_master_unit (
  input  logic             clk,
  input  logic             rst,
  mdio_req_if.sink         req,
  mdio_res_if.source       res,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_data
);
  import mdio_mm_pkg::*;

  // frame phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_PRE    = 3'd1;
  localparam logic [2:0] PH_CMD    = 3'd2;
  localparam logic [2:0] PH_SAMPLE = 3'd3;
  localparam logic [2:0] PH_TRAIL  = 3'd4;

  logic [5:0]  preamble_bits;
  logic [7:0]  half_period_ticks;

  logic [2:0]  phase;
  logic [5:0]  bit_count;
  logic [31:0] out_shift;
  logic [18:0] in_shift;
  logic [7:0]  tick_count;
  logic        write_mode;
  logic        clock_level;
  logic [15:0] held_read_data;

  logic [2:0]  phase_next;
  logic [5:0]  bit_count_next;
  logic [31:0] out_shift_next;
  logic [18:0] in_shift_next;
  logic [7:0]  tick_count_next;
  logic        write_mode_next;
  logic        clock_level_next;
  logic [15:0] held_read_data_next;
  mdio_res_t   res_word;

  logic        accept;
  logic        out_take;
  logic        out_valid;
  mdio_res_t   out_word;
  logic        skid_valid;
  mdio_res_t   skid_word;

  assign accept    = req.valid && req.ready;
  assign out_take  = out_valid && res.ready;
  assign req.ready = !skid_valid;
  assign res.valid = out_valid;
  assign res.data  = out_word;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_bits     <= PREAMBLE_RESET;
      half_period_ticks <= HALF_PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PREAMBLE_BITS: preamble_bits     <= cfg_data[5:0];
        CFG_HALF_PERIOD:   half_period_ticks <= cfg_data;
        default:           preamble_bits     <= preamble_bits;
      endcase
    end
  end

  // one tick of the frame sequencer
  always_comb begin
    logic [7:0] half;
    logic       last_tick;
    logic [5:0] bit_inc;
    logic [5:0] phase_len;

    phase_next          = phase;
    bit_count_next      = bit_count;
    out_shift_next      = out_shift;
    in_shift_next       = in_shift;
    tick_count_next     = tick_count;
    write_mode_next     = write_mode;
    clock_level_next    = clock_level;
    held_read_data_next = held_read_data;
    res_word            = '0;

    // start of a frame, only from idle
    if (phase == PH_IDLE && (req.data.op == OP_READ || req.data.op == OP_WRITE)) begin
      write_mode_next = (req.data.op == OP_WRITE);
      if (req.data.op == OP_WRITE) begin
        out_shift_next = {WRITE_HEADER, req.data.phy_id, req.data.reg_addr, WRITE_TA,
                          req.data.write_data};
      end else begin
        out_shift_next = {READ_HEADER, req.data.phy_id, req.data.reg_addr, 16'h0000};
      end
      bit_count_next   = '0;
      tick_count_next  = '0;
      clock_level_next = 1'b0;
      in_shift_next    = '0;
      phase_next       = (preamble_bits != 6'd0) ? PH_PRE : PH_CMD;
    end

    half      = (half_period_ticks != 8'd0) ? half_period_ticks : 8'd1;
    last_tick = ({1'b0, tick_count_next} + 9'd1) >= {1'b0, half};
    bit_inc   = bit_count_next + 6'd1;

    case (phase_next)
      PH_PRE:    phase_len = preamble_bits;
      PH_CMD:    phase_len = write_mode_next ? WRITE_CMD_BITS : READ_CMD_BITS;
      PH_SAMPLE: phase_len = SAMPLE_BITS;
      default:   phase_len = TRAIL_BITS;
    endcase

    if (phase_next != PH_IDLE) begin
      res_word.busy_res = 1'b1;
      res_word.mdc      = clock_level_next;
      if (phase_next == PH_PRE) begin
        res_word.mdio_drive = 1'b1;
        res_word.mdio_out   = 1'b1;
      end else if (phase_next == PH_CMD) begin
        res_word.mdio_drive = 1'b1;
        res_word.mdio_out   = out_shift_next[31];
      end

      if (!last_tick) begin
        tick_count_next = tick_count_next + 8'd1;
      end else if (!clock_level_next) begin
        // sample just before the rising mdc edge
        if (phase_next == PH_SAMPLE) begin
          in_shift_next = {in_shift_next[17:0], req.data.mdio_in};
        end
        tick_count_next  = '0;
        clock_level_next = 1'b1;
      end else begin
        // end of a bit period
        tick_count_next  = '0;
        clock_level_next = 1'b0;
        if (phase_next == PH_CMD) begin
          out_shift_next = {out_shift_next[30:0], 1'b0};
        end
        bit_count_next = bit_inc;
        if (bit_inc >= phase_len) begin
          bit_count_next = '0;
          case (phase_next)
            PH_PRE: phase_next = PH_CMD;
            PH_CMD: phase_next = write_mode_next ? PH_TRAIL : PH_SAMPLE;
            default: begin
              if (phase_next == PH_SAMPLE) begin
                held_read_data_next = in_shift_next[16:1];
              end
              phase_next        = PH_IDLE;
              res_word.done_res = 1'b1;
            end
          endcase
        end
      end
    end

    res_word.read_data = held_read_data_next;
  end

  // sequencer state, advanced once per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_count      <= '0;
      out_shift      <= '0;
      in_shift       <= '0;
      tick_count     <= '0;
      write_mode     <= 1'b0;
      clock_level    <= 1'b0;
      held_read_data <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      bit_count      <= bit_count_next;
      out_shift      <= out_shift_next;
      in_shift       <= in_shift_next;
      tick_count     <= tick_count_next;
      write_mode     <= write_mode_next;
      clock_level    <= clock_level_next;
      held_read_data <= held_read_data_next;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid || out_take) begin
        out_word <= res_word;
      end else begin
        skid_word <= res_word;
      end
    end else if (out_take && skid_valid) begin
      out_word <= skid_word;
    end
  end

endmodule
